[rtl/core/shs_pkg.sv]
// shared types, constants and functions of the sha-256 stream hasher
// no dependencies; imported by shs_ctrl, shs_datapath and the top level

package shs_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 8;
    localparam int WIN_WORDS = 16;
    localparam int ROUNDS    = 64;
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 6;
    localparam int ROUND_W   = 6;
    localparam int IDX_W     = 3;
    localparam int COUNT_W   = 61;
    localparam int LEN_W     = 64;
    localparam int OUT_DATA_W = 40;

    localparam logic [FILL_W-1:0]  LEN_POS    = 6'd56;
    localparam logic [FILL_W-1:0]  LAST_BYTE  = 6'd63;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
    localparam logic [IDX_W-1:0]   LAST_WORD  = 3'd7;
    localparam logic [BYTE_W-1:0]  PAD_MARK   = 8'h80;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [WORD_W-1:0] START_WORDS [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic                 load_byte;
        byte_src_t            byte_src;
        logic [IDX_W-1:0]     len_idx;
        logic                 count_byte;
        logic                 round_en;
        logic [ROUND_W-1:0]   round_idx;
        logic                 fold;
        logic                 clear_chain;
        logic [IDX_W-1:0]     out_sel;
    } dp_cmd_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[rtl/core/shs_datapath.sv]
// sha-256 datapath: byte window / message schedule, working and chaining words
// depends on shs_pkg; driven by commands from shs_ctrl

module shs_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  shs_pkg::dp_cmd_t              cmd,
    input  logic [shs_pkg::BYTE_W-1:0]    data_byte,
    output logic [shs_pkg::WORD_W-1:0]    digest_word
);
    import shs_pkg::*;

    logic [WORD_W-1:0]  win_reg   [WIN_WORDS];
    logic [WORD_W-1:0]  win_next  [WIN_WORDS];
    logic [WORD_W-1:0]  work_reg  [NUM_WORDS];
    logic [WORD_W-1:0]  work_next [NUM_WORDS];
    logic [WORD_W-1:0]  chain_reg [NUM_WORDS];
    logic [WORD_W-1:0]  chain_next[NUM_WORDS];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [BYTE_W-1:0]  byte_in;
    logic [LEN_W-1:0]   len_bits;
    logic [LEN_W-1:0]   len_shift;
    logic [WORD_W-1:0]  t1;
    logic [WORD_W-1:0]  t2;
    logic [WORD_W-1:0]  ch;
    logic [WORD_W-1:0]  maj;
    logic [WORD_W-1:0]  sched_word;

    // byte entering the window
    assign len_bits  = {count_reg, 3'b000};
    assign len_shift = len_bits >> {~cmd.len_idx, 3'b000};

    always_comb begin
        unique case (cmd.byte_src)
            SRC_DATA: byte_in = data_byte;
            SRC_MARK: byte_in = PAD_MARK;
            SRC_ZERO: byte_in = '0;
            SRC_LEN:  byte_in = len_shift[BYTE_W-1:0];
            default:  byte_in = '0;
        endcase
    end

    // round arithmetic
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch
               + ROUND_K[cmd.round_idx] + win_reg[0];
    assign t2  = big_sigma0(work_reg[0]) + maj;
    assign sched_word = small_sigma1(win_reg[14]) + win_reg[9]
                      + small_sigma0(win_reg[1]) + win_reg[0];

    // window: byte shift on load, word shift with new schedule word on a round
    always_comb begin
        for (int j = 0; j < WIN_WORDS; j++) begin
            win_next[j] = win_reg[j];
        end
        if (cmd.load_byte) begin
            for (int j = 0; j < WIN_WORDS - 1; j++) begin
                win_next[j] = {win_reg[j][WORD_W-BYTE_W-1:0],
                               win_reg[j+1][WORD_W-1 -: BYTE_W]};
            end
            win_next[WIN_WORDS-1] = {win_reg[WIN_WORDS-1][WORD_W-BYTE_W-1:0], byte_in};
        end else if (cmd.round_en) begin
            for (int j = 0; j < WIN_WORDS - 1; j++) begin
                win_next[j] = win_reg[j+1];
            end
            win_next[WIN_WORDS-1] = sched_word;
        end
    end

    // working and chaining words
    always_comb begin
        for (int j = 0; j < NUM_WORDS; j++) begin
            work_next[j]  = work_reg[j];
            chain_next[j] = chain_reg[j];
        end
        if (cmd.clear_chain) begin
            for (int j = 0; j < NUM_WORDS; j++) begin
                work_next[j]  = START_WORDS[j];
                chain_next[j] = START_WORDS[j];
            end
        end else if (cmd.fold) begin
            for (int j = 0; j < NUM_WORDS; j++) begin
                chain_next[j] = chain_reg[j] + work_reg[j];
                work_next[j]  = chain_reg[j] + work_reg[j];
            end
        end else if (cmd.round_en) begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    // message byte count
    always_comb begin
        count_next = count_reg;
        if (cmd.clear_chain) begin
            count_next = '0;
        end else if (cmd.count_byte) begin
            count_next = count_reg + 1'b1;
        end
    end

    // window has no reset; it holds payload, pad and length bytes
    always_ff @(posedge aclk) begin
        for (int j = 0; j < WIN_WORDS; j++) begin
            win_reg[j] <= win_next[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_WORDS; j++) begin
                work_reg[j]  <= START_WORDS[j];
                chain_reg[j] <= START_WORDS[j];
            end
            count_reg <= '0;
        end else begin
            for (int j = 0; j < NUM_WORDS; j++) begin
                work_reg[j]  <= work_next[j];
                chain_reg[j] <= chain_next[j];
            end
            count_reg <= count_next;
        end
    end

    assign digest_word = chain_reg[cmd.out_sel];

endmodule

[rtl/core/shs_ctrl.sv]
// sha-256 stream hasher controller: load, padding, rounds and digest output
// depends on shs_pkg; commands shs_datapath through dp_cmd_t

module shs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_kind,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    output shs_pkg::dp_cmd_t  cmd
);
    import shs_pkg::*;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [IDX_W-1:0]    word_reg, word_next;
    logic                long_tail_reg, long_tail_next;
    logic                pad_resume_reg, pad_resume_next;
    logic                final_reg, final_next;
    logic                s_accept;

    assign s_accept = s_tvalid && s_tready;

    // next state and counters
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        round_next      = round_reg;
        word_next       = word_reg;
        long_tail_next  = long_tail_reg;
        pad_resume_next = pad_resume_reg;
        final_next      = final_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    fill_next = fill_reg + 1'b1;
                    if (s_kind == KIND_BYTE) begin
                        if (fill_reg == LAST_BYTE) begin
                            state_next = ST_ROUND;
                        end
                    end else begin
                        long_tail_next  = (fill_reg >= LEN_POS) && (fill_reg != LAST_BYTE);
                        pad_resume_next = (fill_reg == LAST_BYTE);
                        state_next      = (fill_reg == LAST_BYTE) ? ST_ROUND : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (long_tail_reg) begin
                    fill_next = fill_reg + 1'b1;
                    if (fill_reg == LAST_BYTE) begin
                        long_tail_next  = 1'b0;
                        pad_resume_next = 1'b1;
                        state_next      = ST_ROUND;
                    end
                end else if (fill_reg == LEN_POS) begin
                    state_next = ST_LEN;
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            ST_LEN: begin
                fill_next = fill_reg + 1'b1;
                if (fill_reg == LAST_BYTE) begin
                    final_next = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                round_next = round_reg + 1'b1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                priority if (final_reg) begin
                    word_next  = '0;
                    state_next = ST_EMIT;
                end else if (pad_resume_reg) begin
                    pad_resume_next = 1'b0;
                    state_next      = ST_PAD;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    word_next = word_reg + 1'b1;
                    if (word_reg == LAST_WORD) begin
                        final_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        cmd          = '0;
        cmd.byte_src = SRC_ZERO;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        m_tlast      = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready       = 1'b1;
                cmd.load_byte  = s_accept;
                cmd.count_byte = s_accept && (s_kind == KIND_BYTE);
                cmd.byte_src   = (s_kind == KIND_END) ? SRC_MARK : SRC_DATA;
            end
            ST_PAD: begin
                cmd.load_byte = long_tail_reg || (fill_reg != LEN_POS);
                cmd.byte_src  = SRC_ZERO;
            end
            ST_LEN: begin
                cmd.load_byte = 1'b1;
                cmd.byte_src  = SRC_LEN;
                cmd.len_idx   = fill_reg[IDX_W-1:0];
            end
            ST_ROUND: begin
                cmd.round_en  = 1'b1;
                cmd.round_idx = round_reg;
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
            end
            ST_EMIT: begin
                m_tvalid        = 1'b1;
                m_tlast         = (word_reg == LAST_WORD);
                cmd.out_sel     = word_reg;
                cmd.clear_chain = m_tready && (word_reg == LAST_WORD);
            end
            default: begin
                cmd.byte_src = SRC_ZERO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            fill_reg       <= '0;
            round_reg      <= '0;
            word_reg       <= '0;
            long_tail_reg  <= 1'b0;
            pad_resume_reg <= 1'b0;
            final_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            round_reg      <= round_next;
            word_reg       <= word_next;
            long_tail_reg  <= long_tail_next;
            pad_resume_reg <= pad_resume_next;
            final_reg      <= final_next;
        end
    end

endmodule

[rtl/core/sha256_stream_hasher_core.sv]
// a message byte is loaded into the window; the 64th byte of a block starts a compression
//   (64 rounds of the single round unit plus one fold of the chaining words)
// end item: zero bytes, one per cycle, up to the length field, then a turn without a load,
//   eight length bytes, one or two compressions, eight digest beats, one per cycle if ready
// no new byte is taken while a block is being compressed by the shared round unit
// reset: aresetn synchronous active low, loads the initial hash values, clears counters
module sha256_stream_hasher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);
    import shs_pkg::*;

    dp_cmd_t            cmd;
    logic [WORD_W-1:0]  digest_word;

    shs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd)
    );

    shs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .digest_word (digest_word)
    );

    // pack result beat
    assign m_tdata = {{(OUT_DATA_W - WORD_W - IDX_W){1'b0}}, cmd.out_sel, digest_word};

endmodule

[rtl/core/sha256_stream_hasher_checker.sv]
// port-level checks of the sha-256 stream hasher core
// no package dependency; bound to sha256_stream_hasher_core below

module sha256_stream_hasher_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast
);

    // no input beat taken while the digest is going out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted during digest output");

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // digest words come in order without gaps
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("digest word index out of sequence");

    // last marks word seven only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("last flag does not match word index");

    // digest burst ends after the last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result beat after end of digest");

endmodule

bind sha256_stream_hasher_core sha256_stream_hasher_checker u_checker (.*);
